FILE: hdl/lcar_pkg.sv
package lcar_pkg;

    // Command codes carried in the operation field
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_MEASURE = 3'd1;
    localparam logic [2:0] OP_TARE    = 3'd2;
    localparam logic [2:0] OP_PWR_DN  = 3'd3;
    localparam logic [2:0] OP_PWR_UP  = 3'd4;

    // Configuration register indexes
    localparam logic REG_GAIN_PULSES = 1'b0;
    localparam logic REG_SCALE_RECIP = 1'b1;

    localparam int CNT_W   = 8;
    localparam int AVG_W   = 24;
    localparam int WGT_W   = 32;
    localparam int SCALE_W = 32;

    // Datapath commands issued by the sequencer
    typedef struct packed {
        logic             clear_sum;
        logic             clear_shift;
        logic             shift_in;
        logic             dout;
        logic             accumulate;
        logic             div_load;
        logic             div_step;
        logic             div_fix;
        logic             tare;
        logic             mul;
        logic [CNT_W-1:0] divisor;
    } t_dp_cmd;

    // Result beat control from the sequencer
    typedef struct packed {
        logic load;
        logic sck;
        logic busy;
        logic done;
    } t_res_ctl;

endpackage

FILE: hdl/load_cell_adc_reader.sv
// Channel   Dir  Beat contents
// s_axis    in   one converter clock half-period tick: command, count, data pin
// m_axis    out  one result per tick: clock level, busy, done, average, weight
// cfg       in   write-only registers: 0 gain_pulses, 1 scale_reciprocal
//
// Sequencing: each tick's beat is loaded as the tick is taken, except the tick
// that ends a measure or tare, whose beat waits while the result is computed:
// a divider load, ADC_BITS+8 one-bit steps dividing the sum by the sample
// count, then sign fix, multiply and saturate.
// Reset: i_rst_n synchronous, active low; idle with the converter clock low.
// Stalls: take a tick only outside that computation and while the output beat
// is empty or being taken; a finished result also waits for the output beat.
module load_cell_adc_reader
    import lcar_pkg::*;
#(
    parameter int ADC_BITS    = 24,
    parameter int MAX_SAMPLES = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // [2:0] operation, [10:3] sample_count, [11] dout_level, [15:12] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // [0] sck_level, [1] busy_res, [2] done_res, [26:3] average_value,
    // [58:27] weight, [63:59] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    logic [1:0]         r_gain;
    logic [SCALE_W-1:0] r_scale;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    logic                    ctl_ready;
    logic                    out_free;
    logic                    in_fire;
    t_dp_cmd                 dp_cmd;
    t_res_ctl                res;
    logic signed [AVG_W-1:0] dp_avg;
    logic signed [WGT_W-1:0] dp_weight;
    logic [AVG_W-1:0]        beat_avg;
    logic [WGT_W-1:0]        beat_weight;

    // take a tick only when its beat has somewhere to go
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = ctl_ready && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    lcar_ctrl #(
        .ADC_BITS    (ADC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_op       (s_axis_tdata[2:0]),
        .i_count    (s_axis_tdata[10:3]),
        .i_dout     (s_axis_tdata[11]),
        .i_gain     (r_gain),
        .i_res_free (out_free),
        .o_ready    (ctl_ready),
        .o_cmd      (dp_cmd),
        .o_res      (res)
    );

    lcar_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_scale  (r_scale),
        .o_avg    (dp_avg),
        .o_weight (dp_weight)
    );

    // configuration writes land directly, no handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 2'd1;
            r_scale <= SCALE_W'(32'h0100_0000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GAIN_PULSES: r_gain  <= i_cfg_wdata[1:0];
                REG_SCALE_RECIP: r_scale <= i_cfg_wdata;
                default:         r_scale <= r_scale;
            endcase
        end
    end

    // average and weight are only meaningful on the finishing beat
    assign beat_avg    = res.done ? dp_avg : '0;
    assign beat_weight = res.done ? dp_weight : '0;

    // output register: load a beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_data <= {5'd0, beat_weight, beat_avg, res.done, res.busy, res.sck};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.load |-> (!r_out_valid || m_axis_tready))
        else $error("result beat overwritten before it was taken");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> !m_axis_tdata[1])
        else $error("finishing beat still flagged busy");

endmodule

FILE: hdl/lcar_ctrl.sv
module lcar_ctrl
    import lcar_pkg::*;
#(
    parameter int ADC_BITS    = 24,
    parameter int MAX_SAMPLES = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_fire,
    input  logic [2:0] i_op,
    input  logic [7:0] i_count,
    input  logic       i_dout,
    input  logic [1:0] i_gain,
    input  logic       i_res_free,
    output logic       o_ready,
    output t_dp_cmd    o_cmd,
    output t_res_ctl   o_res
);

    localparam int SUM_W  = ADC_BITS + CNT_W;
    localparam int BC_W   = $clog2(ADC_BITS + 1);
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_DOWN = 4'd1;
    localparam logic [3:0] PH_WAIT = 4'd2;
    localparam logic [3:0] PH_DHI  = 4'd3;
    localparam logic [3:0] PH_DLO  = 4'd4;
    localparam logic [3:0] PH_GHI  = 4'd5;
    localparam logic [3:0] PH_GLO  = 4'd6;
    localparam logic [3:0] PH_LOAD = 4'd7;
    localparam logic [3:0] PH_DIV  = 4'd8;
    localparam logic [3:0] PH_FIX  = 4'd9;
    localparam logic [3:0] PH_MUL  = 4'd10;
    localparam logic [3:0] PH_SAT  = 4'd11;

    logic [3:0]        r_phase, n_phase;
    logic [BC_W-1:0]   r_bit, n_bit;
    logic [1:0]        r_gpc, n_gpc;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  r_target, n_target;
    logic              r_tare, n_tare;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  req_n;

    assign o_ready = (r_phase <= PH_GLO);

    always_comb begin
        req_n = (i_count == '0) ? CNT_W'(1) : i_count;
        if (req_n > CNT_W'(MAX_SAMPLES)) begin
            req_n = CNT_W'(MAX_SAMPLES);
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_gpc    = r_gpc;
        n_left   = r_left;
        n_target = r_target;
        n_tare   = r_tare;
        n_step   = r_step;
        o_cmd    = '0;
        o_cmd.divisor = r_target;
        o_cmd.dout    = i_dout;
        o_cmd.tare    = r_tare;
        o_res    = '0;
        if (i_in_fire) begin
            o_res.load = 1'b1;
            o_res.busy = 1'b1;
            unique case (r_phase)
                PH_WAIT: begin
                    if (!i_dout) begin
                        n_phase = PH_DHI;
                        n_bit   = '0;
                        o_cmd.clear_shift = 1'b1;
                    end
                end
                PH_DHI: begin
                    o_res.sck      = 1'b1;
                    o_cmd.shift_in = 1'b1;
                    n_bit          = r_bit + BC_W'(1);
                    n_phase        = PH_DLO;
                end
                PH_DLO: begin
                    if (r_bit >= BC_W'(ADC_BITS)) begin
                        n_gpc   = (i_gain == 2'd0) ? 2'd1 : i_gain;
                        n_phase = PH_GHI;
                    end else begin
                        n_phase = PH_DHI;
                    end
                end
                PH_GHI: begin
                    o_res.sck = 1'b1;
                    n_phase   = PH_GLO;
                end
                PH_GLO: begin
                    n_gpc = r_gpc - 2'd1;
                    if (n_gpc != 2'd0) begin
                        n_phase = PH_GHI;
                    end else begin
                        o_cmd.accumulate = 1'b1;
                        n_left = r_left - CNT_W'(1);
                        if (n_left != '0) begin
                            n_phase = PH_WAIT;
                        end else begin
                            // hold the beat until the average and weight are ready
                            o_res.load = 1'b0;
                            n_phase    = PH_LOAD;
                        end
                    end
                end
                default: begin
                    o_res.busy = 1'b0;
                    priority if (i_op == OP_MEASURE || i_op == OP_TARE) begin
                        n_tare   = (i_op == OP_TARE);
                        n_target = req_n;
                        n_left   = req_n;
                        n_bit    = '0;
                        n_phase  = PH_WAIT;
                        o_cmd.clear_sum   = 1'b1;
                        o_cmd.clear_shift = 1'b1;
                        o_res.busy = 1'b1;
                    end else if (i_op == OP_PWR_DN) begin
                        n_phase   = PH_DOWN;
                        o_res.sck = 1'b1;
                    end else if (i_op == OP_PWR_UP) begin
                        n_phase = PH_IDLE;
                    end else begin
                        o_res.sck = (r_phase == PH_DOWN);
                    end
                end
            endcase
        end else begin
            unique case (r_phase)
                PH_LOAD: begin
                    o_cmd.div_load = 1'b1;
                    n_step  = '0;
                    n_phase = PH_DIV;
                end
                PH_DIV: begin
                    o_cmd.div_step = 1'b1;
                    n_step = r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        n_phase = PH_FIX;
                    end
                end
                PH_FIX: begin
                    o_cmd.div_fix = 1'b1;
                    n_phase = PH_MUL;
                end
                PH_MUL: begin
                    o_cmd.mul = 1'b1;
                    n_phase   = PH_SAT;
                end
                PH_SAT: begin
                    // hold the finished result until the output register is free
                    if (i_res_free) begin
                        o_res.load = 1'b1;
                        o_res.done = 1'b1;
                        n_phase    = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bit    <= '0;
            r_gpc    <= '0;
            r_left   <= '0;
            r_target <= CNT_W'(1);
            r_tare   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_gpc    <= n_gpc;
            r_left   <= n_left;
            r_target <= n_target;
            r_tare   <= n_tare;
            r_step   <= n_step;
        end
    end

    a_fix_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIX) |->
            ($past(r_phase) == PH_DIV && $past(r_step) == STEP_W'(SUM_W - 1)))
        else $error("division finished early");

    a_no_accept_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |-> o_ready)
        else $error("tick accepted while computing");

endmodule

FILE: hdl/lcar_dp.sv
module lcar_dp
    import lcar_pkg::*;
#(
    parameter int ADC_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [SCALE_W-1:0]       i_scale,
    output logic signed [AVG_W-1:0]  o_avg,
    output logic signed [WGT_W-1:0]  o_weight
);

    localparam int SUM_W  = ADC_BITS + CNT_W;
    localparam int PROD_W = ADC_BITS + 1 + SCALE_W + 1;
    localparam int SH_W   = PROD_W - 8;

    logic signed [ADC_BITS-1:0] r_shift;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [ADC_BITS-1:0] r_offset;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic                       r_neg;
    logic signed [ADC_BITS-1:0] r_avg;
    logic                       r_tare;
    logic signed [PROD_W-1:0]   r_prod;

    logic [CNT_W:0]             rem_sh;
    logic [CNT_W:0]             rem_sub;
    logic [SUM_W-1:0]           quo_signed;
    logic signed [ADC_BITS:0]   diff;
    logic signed [SCALE_W:0]    scale_s;
    logic signed [SH_W-1:0]     prod_sh;
    logic [SH_W-WGT_W:0]        prod_hi;
    logic signed [WGT_W-1:0]    sat;

    assign rem_sh     = {r_rem, r_quo[SUM_W-1]};
    assign rem_sub    = rem_sh - {1'b0, i_cmd.divisor};
    assign quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign diff       = (ADC_BITS+1)'(r_avg) - (ADC_BITS+1)'(r_offset);
    assign scale_s    = {1'b0, i_scale};

    // Q8.24 product down to Q16.16, floor, then clamp to 32 bits
    assign prod_sh = SH_W'(r_prod >>> 8);
    assign prod_hi = prod_sh[SH_W-1:WGT_W-1];
    always_comb begin
        if ((&prod_hi) || !(|prod_hi)) begin
            sat = prod_sh[WGT_W-1:0];
        end else if (prod_sh[SH_W-1]) begin
            sat = {1'b1, {(WGT_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(WGT_W-1){1'b1}}};
        end
    end

    assign o_avg    = AVG_W'(r_avg);
    assign o_weight = r_tare ? '0 : sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cmd.div_fix && i_cmd.tare) begin
            r_offset <= quo_signed[ADC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_shift) begin
            r_shift <= '0;
        end else if (i_cmd.shift_in) begin
            r_shift <= {r_shift[ADC_BITS-2:0], i_cmd.dout};
        end

        if (i_cmd.clear_sum) begin
            r_sum <= '0;
        end else if (i_cmd.accumulate) begin
            r_sum <= r_sum + SUM_W'(r_shift);
        end

        // restoring divide on the magnitude, one quotient bit a cycle
        if (i_cmd.div_load) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!rem_sub[CNT_W]) begin
                r_rem <= rem_sub[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end

        if (i_cmd.div_fix) begin
            r_avg  <= quo_signed[ADC_BITS-1:0];
            r_tare <= i_cmd.tare;
        end

        if (i_cmd.mul) begin
            r_prod <= diff * scale_s;
        end
    end

endmodule

FILE: dv/tb_load_cell_adc_reader.sv
module tb_load_cell_adc_reader;
    import lcar_pkg::*;

    localparam int ADC_BITS     = 24;
    localparam int STALL_LIMIT  = 3000;   // cycles with no beat on either side
    localparam int HOLD_CYCLES  = 250;    // long receiver hold-off
    localparam int RANDOM_TICKS = 150;
    localparam int DRAIN_CYCLES = ADC_BITS + 20;
    localparam longint WGT_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint WGT_MIN  = -WGT_MAX - 1;

    // Sequencer phases of the converter interface
    typedef enum logic [2:0] {
        ST_IDLE, ST_DOWN, ST_WAIT, ST_DHI, ST_DLO, ST_GHI, ST_GLO
    } conv_phase_t;

    // Same layout as m_axis_tdata[58:0]
    typedef struct packed {
        logic [WGT_W-1:0] wt;
        logic [AVG_W-1:0] avg;
        logic             done;
        logic             busy;
        logic             sck;
    } tick_result_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    // [2:0] operation, [10:3] sample_count, [11] dout_level, [15:12] zero
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    // [0] sck_level, [1] busy_res, [2] done_res, [26:3] average_value,
    // [58:27] weight, [63:59] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = 1'b0;
    logic [31:0] i_cfg_wdata   = '0;

    load_cell_adc_reader dut (.*);

    // Predicted converter-interface state, kept in step with accepted ticks
    conv_phase_t              cv_phase     = ST_IDLE;
    logic [4:0]               cv_bits      = '0;
    logic [ADC_BITS-1:0]      cv_shift     = '0;
    logic [1:0]               cv_gain_left = '0;
    logic [CNT_W-1:0]         cv_left      = '0;
    logic [CNT_W-1:0]         cv_target    = 8'd1;
    longint                   cv_sum       = 0;
    logic signed [AVG_W-1:0]  cv_offset    = '0;
    logic                     cv_sck       = 1'b0;
    logic                     cv_tare      = 1'b0;
    logic [1:0]               cfg_gain     = 2'd1;
    logic [SCALE_W-1:0]       cfg_scale    = 32'h0100_0000;

    tick_result_t        expected_ticks[$];
    logic [ADC_BITS-1:0] conv_words[$];    // words the converter presents
    int                  n_mismatch = 0;
    int                  n_sent     = 0;
    bit                  gaps_on    = 1'b1;
    bit                  hold_req   = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Advance the predicted interface by one half-period tick and return the
    // result beat it must produce.
    function automatic tick_result_t predict_tick(input logic [2:0] op,
                                                  input logic [7:0] cnt,
                                                  input logic dout);
        tick_result_t r;
        longint       avg;
        longint       prod;
        longint       wt;
        r      = '0;
        r.busy = 1'b1;
        avg    = 0;
        wt     = 0;
        case (cv_phase)
            ST_WAIT: begin
                // hold the clock low until the converter pulls its data pin low
                cv_sck = 1'b0;
                if (!dout) begin
                    cv_phase = ST_DHI;
                    cv_bits  = '0;
                    cv_shift = '0;
                end
            end
            ST_DHI: begin
                // sample on the high phase, MSB first
                cv_sck   = 1'b1;
                cv_shift = {cv_shift[ADC_BITS-2:0], dout};
                cv_bits  = cv_bits + 5'd1;
                cv_phase = ST_DLO;
            end
            ST_DLO: begin
                cv_sck = 1'b0;
                if (cv_bits >= ADC_BITS) begin
                    cv_gain_left = (cfg_gain == 2'd0) ? 2'd1 : cfg_gain;
                    cv_phase     = ST_GHI;
                end else begin
                    cv_phase = ST_DHI;
                end
            end
            ST_GHI: begin
                cv_sck   = 1'b1;
                cv_phase = ST_GLO;
            end
            ST_GLO: begin
                cv_sck       = 1'b0;
                cv_gain_left = cv_gain_left - 2'd1;
                if (cv_gain_left != 2'd0) begin
                    cv_phase = ST_GHI;
                end else begin
                    cv_sum  = cv_sum + longint'($signed(cv_shift));
                    cv_left = cv_left - 8'd1;
                    if (cv_left != 8'd0) begin
                        cv_phase = ST_WAIT;
                    end else begin
                        // truncating average, then offset and Q8.24 scale
                        avg = cv_sum / longint'(cv_target);
                        if (cv_tare) begin
                            cv_offset = avg[AVG_W-1:0];
                        end else begin
                            prod = (avg - longint'(cv_offset)) * longint'(cfg_scale);
                            wt   = prod >>> 8;
                            if (wt > WGT_MAX) wt = WGT_MAX;
                            if (wt < WGT_MIN) wt = WGT_MIN;
                        end
                        cv_phase = ST_IDLE;
                        r.busy   = 1'b0;
                        r.done   = 1'b1;
                    end
                end
            end
            default: begin
                // idle or powered down: commands take effect here only
                r.busy = 1'b0;
                if (op == OP_MEASURE || op == OP_TARE) begin
                    cv_tare   = (op == OP_TARE);
                    cv_target = (cnt == 8'd0) ? 8'd1 : cnt;
                    cv_left   = cv_target;
                    cv_sum    = 0;
                    cv_bits   = '0;
                    cv_shift  = '0;
                    cv_phase  = ST_WAIT;
                    cv_sck    = 1'b0;
                    r.busy    = 1'b1;
                end else if (op == OP_PWR_DN) begin
                    cv_phase = ST_DOWN;
                    cv_sck   = 1'b1;
                end else if (op == OP_PWR_UP) begin
                    cv_phase = ST_IDLE;
                    cv_sck   = 1'b0;
                end else begin
                    if (cv_phase != ST_DOWN) cv_phase = ST_IDLE;
                    cv_sck = (cv_phase == ST_DOWN);
                end
            end
        endcase
        r.sck = cv_sck;
        r.avg = avg[AVG_W-1:0];
        r.wt  = wt[WGT_W-1:0];
        return r;
    endfunction

    // Offer one tick, optionally after a gap, and predict it once accepted
    task automatic send_tick(input logic [2:0] op, input logic [7:0] cnt,
                             input logic dout);
        if (gaps_on && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, dout, cnt, op};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_ticks.push_back(predict_tick(op, cnt, dout));
        n_sent++;
    endtask

    // Start a measure or tare and play the converter until it finishes.
    // Words come from conv_words in order; missing ones are random.
    task automatic run_sequence(input logic [2:0] op, input logic [7:0] cnt,
                                input int hi_pct);
        logic [2:0] nop;
        logic       d;
        int         idx;
        send_tick(op, cnt, 1'($urandom_range(1)));
        while (cv_phase != ST_IDLE && cv_phase != ST_DOWN) begin
            // commands while busy must be ignored
            nop = OP_TICK;
            if ($urandom_range(99) < 15) nop = 3'($urandom_range(7));
            case (cv_phase)
                ST_WAIT: d = ($urandom_range(99) < hi_pct);
                ST_DHI: begin
                    idx = int'(cv_target) - int'(cv_left);
                    if (idx < conv_words.size())
                        d = conv_words[idx][ADC_BITS-1-int'(cv_bits)];
                    else
                        d = 1'($urandom_range(1));
                end
                default: d = 1'($urandom_range(1));
            endcase
            send_tick(nop, 8'($urandom), d);
        end
        conv_words.delete();
    endtask

    // Drop valid, wait for every expected beat, then let the divider drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic addr, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == REG_GAIN_PULSES)
            cfg_gain = value[1:0];
        else
            cfg_scale = value;
        @(posedge i_clk);
    endtask

    task automatic check_beat(input logic [63:0] beat);
        tick_result_t want;
        tick_result_t got;
        got = beat[58:0];
        if (expected_ticks.size() == 0) begin
            if (n_mismatch < 10)
                $display("unexpected beat at %0t: %h", $time, beat);
            n_mismatch++;
        end else begin
            want = expected_ticks.pop_front();
            if (got.sck !== want.sck || got.busy !== want.busy ||
                got.done !== want.done || got.avg !== want.avg ||
                got.wt !== want.wt || beat[63:59] !== 5'd0) begin
                if (n_mismatch < 10) begin
                    $display("mismatch at %0t: want sck=%0b busy=%0b done=%0b avg=%0d wt=%0d",
                             $time, want.sck, want.busy, want.done,
                             $signed(want.avg), $signed(want.wt));
                    $display("                 got  sck=%0b busy=%0b done=%0b avg=%0d wt=%0d pad=%b",
                             got.sck, got.busy, got.done,
                             $signed(got.avg), $signed(got.wt), beat[63:59]);
                end
                n_mismatch++;
            end
        end
    endtask

    // Power modes, repeats and unused codes, then a measure from power-down
    task automatic test_power_modes();
        send_tick(OP_TICK, 8'h00, 1'b0);
        send_tick(3'd5, 8'hFF, 1'b1);
        send_tick(OP_PWR_DN, 8'hFF, 1'b1);
        send_tick(OP_TICK, 8'h55, 1'b0);
        send_tick(OP_PWR_DN, 8'hAA, 1'b0);
        send_tick(3'd6, 8'h00, 1'b1);
        send_tick(3'd7, 8'h80, 1'b0);
        send_tick(OP_PWR_UP, 8'h01, 1'b1);
        send_tick(OP_PWR_UP, 8'h7F, 1'b0);
        send_tick(3'd7, 8'hFE, 1'b1);
        send_tick(OP_PWR_DN, 8'h00, 1'b0);
        conv_words.push_back(24'h00_1234);
        run_sequence(OP_MEASURE, 8'd1, 0);
    endtask

    // Zero count, tare with a stuck data pin, multi-sample average
    task automatic test_counts_and_wait();
        conv_words.push_back(24'h7F_FFFF);
        run_sequence(OP_MEASURE, 8'd0, 0);
        conv_words.push_back(24'h80_0000);
        conv_words.push_back(24'h00_0001);
        run_sequence(OP_TARE, 8'd2, 96);
        conv_words.push_back(24'hFF_FFFF);
        conv_words.push_back(24'h00_0000);
        conv_words.push_back(24'h12_3456);
        run_sequence(OP_MEASURE, 8'd3, 40);
    endtask

    // Every gain setting, zero included
    task automatic test_gain_settings();
        for (int g = 0; g < 4; g++) begin
            settle();
            write_cfg(REG_GAIN_PULSES, 32'(g));
            run_sequence(OP_MEASURE, 8'd1, 20);
        end
    endtask

    // Scale at both ends, saturation both ways, rounding toward minus infinity
    task automatic test_scale_extremes();
        settle();
        write_cfg(REG_GAIN_PULSES, 32'h5A5A_5A52);   // upper bits ignored
        conv_words.push_back(24'h00_0000);
        run_sequence(OP_TARE, 8'd1, 0);
        settle();
        write_cfg(REG_SCALE_RECIP, 32'hFFFF_FFFF);
        conv_words.push_back(24'h7F_FFFF);
        run_sequence(OP_MEASURE, 8'd1, 0);
        conv_words.push_back(24'h80_0000);
        run_sequence(OP_MEASURE, 8'd1, 0);
        settle();
        write_cfg(REG_SCALE_RECIP, 32'h0000_0000);
        run_sequence(OP_MEASURE, 8'd1, 0);
        settle();
        write_cfg(REG_SCALE_RECIP, 32'h0000_0001);
        conv_words.push_back(24'hFF_FFFF);
        run_sequence(OP_MEASURE, 8'd1, 0);
        conv_words.push_back(24'h7F_FFFF);
        run_sequence(OP_TARE, 8'd1, 0);
        settle();
        write_cfg(REG_SCALE_RECIP, 32'hFFFF_FFFF);
        conv_words.push_back(24'h80_0000);
        run_sequence(OP_MEASURE, 8'd1, 0);
        settle();
        write_cfg(REG_SCALE_RECIP, 32'h0100_0000);
    endtask

    // Most negative word averaged over two samples
    task automatic test_full_count();
        settle();
        write_cfg(REG_GAIN_PULSES, 32'd1);
        repeat (2) conv_words.push_back(24'h80_0000);
        run_sequence(OP_MEASURE, 8'd2, 0);
    endtask

    // Receiver holds off for a long stretch while ticks keep coming
    task automatic test_output_stall();
        settle();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        run_sequence(OP_TARE, 8'd2, 10);
        gaps_on  = 1'b1;
    endtask

    function automatic logic [ADC_BITS-1:0] pick_word();
        case ($urandom_range(9))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'hFF_FFFF;
            3: return 24'h00_0000;
            4, 5: return 24'($signed(11'($urandom)));   // near zero
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0100_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly complete sequences with random content, some idle noise and
    // occasional register changes between sequences
    task automatic test_random_ticks();
        int         start;
        int         r;
        int         cnt;
        logic [2:0] op;
        start   = n_sent;
        gaps_on = 1'b0;   // long stretch with no idling on either side
        while (n_sent - start < RANDOM_TICKS) begin
            if (n_sent - start > 100) gaps_on = 1'b1;
            r = $urandom_range(99);
            if (r < 6) begin
                settle();
                write_cfg(REG_GAIN_PULSES, 32'($urandom_range(3)));
                if ($urandom_range(1)) write_cfg(REG_SCALE_RECIP, pick_scale());
            end else if (r < 75) begin
                r = $urandom_range(99);
                if (r < 70)      cnt = $urandom_range(1, 2);
                else if (r < 80) cnt = 0;
                else if (r < 95) cnt = $urandom_range(3, 5);
                else             cnt = $urandom_range(6, 9);
                for (int k = 0; k < ((cnt == 0) ? 1 : cnt); k++)
                    conv_words.push_back(pick_word());
                op = ($urandom_range(3) == 0) ? OP_TARE : OP_MEASURE;
                run_sequence(op, 8'(cnt), $urandom_range(60));
            end else begin
                op = 3'($urandom_range(7));
                if (op == OP_MEASURE || op == OP_TARE)
                    op = OP_TICK;
                send_tick(op, 8'($urandom), 1'($urandom_range(1)));
            end
        end
    endtask

    // Check every accepted result beat and drive the receiver's ready
    initial begin : result_monitor
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(gaps_on && $urandom_range(99) < 30);
            end
        end
    end

    // End the run when no beat moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_modes();
        test_counts_and_wait();
        test_gain_settings();
        test_scale_extremes();
        test_full_count();
        test_output_stall();
        test_random_ticks();
        settle();
        if (n_mismatch == 0 && expected_ticks.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
